// File: rtl/core/mru_key_list_core_assert.svh
// Assertion macros for the MRU key list core.
// Used by mru_key_list_core; expects clk and rst_n in the including scope.
`ifndef MRU_KEY_LIST_CORE_ASSERT_SVH
`define MRU_KEY_LIST_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MKL_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mru_key_list_core: invariant violated");
`define MKL_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mru_key_list_core: implication violated");
`else
`define MKL_ASSERT_ALWAYS(lbl, expr)
`define MKL_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

// File: rtl/core/mkl_pkg.sv
// Shared constants for the MRU key list core.
// No dependencies.
package mkl_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 128;
  localparam int OP_W  = 3;

  localparam logic [OP_W-1:0] OP_TOUCH     = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_INDEX = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

endpackage

// File: rtl/core/mru_key_list_core.sv
// MRU key list: keeps up to 16 keys of 128 bits, most recent first, in one
// synchronous key memory (one read, one write per cycle, registered read data).
// One operation is in work at a time; a finished result waits in the output
// register while the next beat is accepted. Delete by key and touch search the
// list from the front; a move pass then shifts the entries (up to 15), and touch
// writes its key at the front. The single memory read port steps one entry per
// cycle through the search and the shift.
// Depends on mkl_pkg and mru_key_list_core_assert.svh.
`include "mru_key_list_core_assert.svh"

module mru_key_list_core
  import mkl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [63:0]      in_key_high,
  input  logic [63:0]      in_key_low,
  input  logic [IDX_W-1:0] in_position,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_success,
  output logic [CNT_W-1:0] out_entry_count,
  output logic [63:0]      out_found_high,
  output logic [63:0]      out_found_low
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_MOVE, S_FRONT, S_RDATA, S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] max_r, max_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             up_r, up_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic [KEY_W-1:0] rd_data_r;
  logic             ok_r, ok_nxt;
  logic [KEY_W-1:0] found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [KEY_W-1:0] out_found_r, out_found_nxt;

  logic [KEY_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [KEY_W-1:0] mem_wd;

  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] cfg_cap;
  logic             issue;
  logic             key_hit;
  logic             in_fire;
  logic [CNT_W-1:0] top;
  logic [CNT_W-1:0] at;

  assign cap     = (max_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_r;
  assign cfg_cap = (cfg_wr_data > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_wr_data;
  assign issue   = (left_r != '0);
  assign key_hit = rd_vld_r && (rd_data_r == key_r);
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[ptr_r];
    rd_idx_r  <= ptr_r;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    used_nxt      = used_r;
    max_nxt       = max_r;
    up_nxt        = up_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    out_found_nxt = out_found_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = key_r;
    top           = '0;
    at            = '0;
    // advance the read walk one entry per cycle
    ptr_nxt    = issue ? (up_r ? ptr_r - 1'b1 : ptr_r + 1'b1) : ptr_r;
    left_nxt   = issue ? left_r - 1'b1 : left_r;
    rd_vld_nxt = issue;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_operation;
          key_nxt   = {in_key_high, in_key_low};
          pos_nxt   = in_position;
          ok_nxt    = 1'b0;
          found_nxt = '0;
          state_nxt = S_FINISH;
          if (cap != '0) begin
            unique case (in_operation)
              OP_TOUCH: begin
                if (used_r == '0) begin
                  used_nxt  = CNT_W'(1);
                  state_nxt = S_FRONT;
                end else begin
                  ptr_nxt   = '0;
                  left_nxt  = used_r;
                  up_nxt    = 1'b0;
                  state_nxt = S_SEARCH;
                end
              end
              OP_DEL_INDEX: begin
                if ({1'b0, in_position} < used_r) begin
                  ptr_nxt   = in_position + 1'b1;
                  left_nxt  = used_r - 1'b1 - {1'b0, in_position};
                  up_nxt    = 1'b0;
                  state_nxt = S_MOVE;
                end
              end
              OP_DEL_KEY: begin
                if (used_r != '0) begin
                  ptr_nxt   = '0;
                  left_nxt  = used_r;
                  up_nxt    = 1'b0;
                  state_nxt = S_SEARCH;
                end
              end
              OP_CLEAR: begin
                used_nxt = '0;
                ok_nxt   = 1'b1;
              end
              OP_READ: begin
                if ({1'b0, in_position} < used_r) begin
                  ptr_nxt   = in_position;
                  left_nxt  = CNT_W'(1);
                  state_nxt = S_RDATA;
                end
              end
              default: begin
                ok_nxt = 1'b0;
              end
            endcase
          end
        end
      end

      S_SEARCH: begin
        if (key_hit || (left_r == '0 && !rd_vld_r)) begin
          rd_vld_nxt = 1'b0;
          if (key_hit) begin
            at = {1'b0, rd_idx_r};
          end
          if (op_r == OP_TOUCH) begin
            if (key_hit) begin
              top = at;
            end else if (used_r < cap) begin
              top      = used_r;
              used_nxt = used_r + 1'b1;
            end else begin
              top      = cap - 1'b1;
              used_nxt = cap;
            end
            // shift entries below top down by one, oldest first
            ptr_nxt   = IDX_W'(top - 1'b1);
            left_nxt  = top;
            up_nxt    = 1'b1;
            state_nxt = S_MOVE;
          end else if (key_hit) begin
            ptr_nxt   = IDX_W'(at + 1'b1);
            left_nxt  = used_r - 1'b1 - at;
            up_nxt    = 1'b0;
            state_nxt = S_MOVE;
          end else begin
            left_nxt  = '0;
            ok_nxt    = 1'b1;
            state_nxt = S_FINISH;
          end
        end
      end

      S_MOVE: begin
        if (rd_vld_r) begin
          mem_we = 1'b1;
          mem_wa = up_r ? rd_idx_r + 1'b1 : rd_idx_r - 1'b1;
          mem_wd = rd_data_r;
        end
        if (left_r == '0 && !rd_vld_r) begin
          if (up_r) begin
            state_nxt = S_FRONT;
          end else begin
            used_nxt  = used_r - 1'b1;
            ok_nxt    = 1'b1;
            state_nxt = S_FINISH;
          end
        end
      end

      S_FRONT: begin
        mem_we    = 1'b1;
        mem_wa    = '0;
        mem_wd    = key_r;
        ok_nxt    = 1'b1;
        state_nxt = S_FINISH;
      end

      S_RDATA: begin
        if (rd_vld_r) begin
          found_nxt = rd_data_r;
          ok_nxt    = 1'b1;
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_cnt_nxt   = used_r;
          out_found_nxt = found_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // capacity write truncates from the old end
    if (cfg_wr_en) begin
      max_nxt = cfg_wr_data;
      if (used_nxt > cfg_cap) begin
        used_nxt = cfg_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      max_r       <= '0;
      left_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      up_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      max_r       <= max_nxt;
      left_r      <= left_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      up_r        <= up_nxt;
    end
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    pos_r       <= pos_nxt;
    ok_r        <= ok_nxt;
    found_r     <= found_nxt;
    out_ok_r    <= out_ok_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_ok_r;
  assign out_entry_count = out_cnt_r;
  assign out_found_high  = out_found_r[KEY_W-1:64];
  assign out_found_low   = out_found_r[63:0];

  `MKL_ASSERT_ALWAYS(a_used_le_cap, used_r <= cap)
  `MKL_ASSERT_IMPLIES(a_write_phase, mem_we, state_r == S_MOVE || state_r == S_FRONT)
  `MKL_ASSERT_IMPLIES(a_reject_no_key, out_valid_r && !out_ok_r, out_found_r == '0)
  `MKL_ASSERT_IMPLIES(a_read_in_range, state_r == S_RDATA, ({1'b0, pos_r} < used_r))

endmodule

// File: tb/testbench.sv
// Self-checking bench for mru_key_list_core: directed touch, delete, clear and
// read beats, then random traffic checked against an in-bench model of the list.
// Depends on mkl_pkg and the mru_key_list_core RTL.
`timescale 1ns / 100ps

module testbench;
  import mkl_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 48;
  localparam int POOL_SIZE    = 20;
  localparam int POOL_IDX_W   = $clog2(POOL_SIZE);
  localparam int CHUNK_ITEMS  = 50;
  localparam int CHUNKS       = 5;

  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic             success;
    logic [CNT_W-1:0] entry_count;
    logic [63:0]      found_high;
    logic [63:0]      found_low;
  } mru_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  in_operation = OP_TOUCH;
  logic [63:0]      in_key_high = '0;
  logic [63:0]      in_key_low = '0;
  logic [IDX_W-1:0] in_position = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_success;
  logic [CNT_W-1:0] out_entry_count;
  logic [63:0]      out_found_high;
  logic [63:0]      out_found_low;

  // Model of the list, most recent at index 0
  logic [KEY_W-1:0] list_keys [DEPTH];
  int unsigned      list_count = 0;
  int unsigned      list_max = 0;

  mru_result_t      pending_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      send_idle_pct = 21;
  int unsigned      recv_stall_pct = 80;
  int unsigned      cycle_count = 0;
  int unsigned      mismatch_count = 0;

  mru_key_list_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key_high     (in_key_high),
    .in_key_low      (in_key_low),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_success     (out_success),
    .out_entry_count (out_entry_count),
    .out_found_high  (out_found_high),
    .out_found_low   (out_found_low)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mru_key_list_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int unsigned list_capacity();
    return (list_max < DEPTH) ? list_max : DEPTH;
  endfunction

  function automatic int unsigned list_find(logic [KEY_W-1:0] key);
    for (int unsigned i = 0; i < list_count; i++) begin
      if (list_keys[IDX_W'(i)] == key) return i;
    end
    return list_count;
  endfunction

  // Close the gap left by the entry at idx
  function automatic void list_remove(int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_count; i++) begin
      list_keys[IDX_W'(i)] = list_keys[IDX_W'(i + 1)];
    end
    list_count--;
  endfunction

  function automatic mru_result_t apply_operation(logic [OP_W-1:0] op,
                                                  logic [KEY_W-1:0] key,
                                                  logic [IDX_W-1:0] pos);
    mru_result_t res;
    int unsigned cap;
    int unsigned hit;
    res = '0;
    cap = list_capacity();
    hit = list_find(key);
    if (cap != 0) begin
      case (op)
        OP_TOUCH: begin
          if (hit < list_count) begin
            list_remove(hit);
          end else if (list_count >= cap) begin
            list_count = cap - 1;
          end
          for (int unsigned i = list_count; i > 0; i--) begin
            list_keys[IDX_W'(i)] = list_keys[IDX_W'(i - 1)];
          end
          list_keys[0] = key;
          list_count++;
          res.success = 1'b1;
        end
        OP_DEL_INDEX: begin
          if (pos < list_count) begin
            list_remove(pos);
            res.success = 1'b1;
          end
        end
        OP_DEL_KEY: begin
          if (list_count != 0) begin
            if (hit < list_count) list_remove(hit);
            res.success = 1'b1;
          end
        end
        OP_CLEAR: begin
          list_count = 0;
          res.success = 1'b1;
        end
        OP_READ: begin
          if (pos < list_count) begin
            {res.found_high, res.found_low} = list_keys[pos];
            res.success = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.entry_count = list_count[CNT_W-1:0];
    return res;
  endfunction

  // Present one beat and return after the edge that accepts it; valid stays
  // high so a following beat can go out back to back.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [IDX_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_high  <= key[KEY_W-1:64];
    in_key_low   <= key[63:0];
    in_position  <= pos;
    pending_results.push_back(apply_operation(op, key, pos));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle_list();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_entries(input logic [CNT_W-1:0] value);
    settle_list();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    list_max = value;
    if (list_count > list_capacity()) list_count = list_capacity();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        mru_result_t want;
        want = pending_results.pop_front();
        if (out_success !== want.success) begin
          $error("success: expected %0h, got %0h", want.success, out_success);
          mismatch_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          mismatch_count++;
        end
        if (out_found_high !== want.found_high) begin
          $error("found_high: expected %h, got %h", want.found_high, out_found_high);
          mismatch_count++;
        end
        if (out_found_low !== want.found_low) begin
          $error("found_low: expected %h, got %h", want.found_low, out_found_low);
          mismatch_count++;
        end
      end
    end
  end

  // Capacity still zero from reset: everything is rejected
  task automatic test_disabled_list();
    send_beat(OP_TOUCH, '1, '0);
    send_beat(OP_DEL_INDEX, '0, '0);
    send_beat(OP_DEL_KEY, '1, '1);
    send_beat(OP_CLEAR, '0, '0);
    send_beat(OP_READ, '0, '0);
    send_beat(OP_RSVD_7, '1, '1);
  endtask

  task automatic test_small_list();
    logic [KEY_W-1:0] key_c;
    logic [KEY_W-1:0] key_d;
    key_c = {$urandom, $urandom, $urandom, $urandom};
    key_d = key_c ^ KEY_W'(1);
    write_max_entries(CNT_W'(2));
    send_beat(OP_TOUCH, '1, '0);
    send_beat(OP_TOUCH, '0, '0);
    send_beat(OP_TOUCH, '1, '0);        // hit moves to front
    send_beat(OP_TOUCH, key_c, '0);     // full: evict the oldest
    send_beat(OP_READ, '0, IDX_W'(0));
    send_beat(OP_READ, '0, IDX_W'(1));
    send_beat(OP_READ, '0, IDX_W'(2));  // past the count
    send_beat(OP_DEL_INDEX, '0, '1);
    send_beat(OP_DEL_KEY, key_d, '0);   // near miss, still accepted
    send_beat(OP_DEL_INDEX, '0, IDX_W'(1));
    send_beat(OP_DEL_KEY, key_c, '0);
    send_beat(OP_DEL_KEY, key_c, '0);   // empty list
    send_beat(OP_TOUCH, key_d, '0);
    send_beat(OP_RSVD_6, key_d, '0);
    send_beat(OP_CLEAR, '0, '0);
    send_beat(OP_READ, '0, IDX_W'(0));
  endtask

  // Shrink the capacity under a populated list
  task automatic test_truncation();
    write_max_entries('1);
    repeat (3) send_beat(OP_TOUCH, {$urandom, $urandom, $urandom, $urandom}, '0);
    write_max_entries(CNT_W'(1));
    send_beat(OP_READ, '0, IDX_W'(0));
    send_beat(OP_READ, '0, IDX_W'(1));
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] setting;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] pos;
    int unsigned      roll;
    // Pairs of keys one bit apart exercise the full-width compare
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 1) begin
        key_pool[POOL_IDX_W'(i)] = key_pool[POOL_IDX_W'(i - 1)] ^
                                   (KEY_W'(1) << $urandom_range(KEY_W - 1));
      end else begin
        key_pool[POOL_IDX_W'(i)] = {$urandom, $urandom, $urandom, $urandom};
      end
    end
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 21;
          recv_stall_pct = 80;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 21;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        case (chunk)
          0: setting = CNT_W'(DEPTH);
          1: setting = CNT_W'(1);
          2: setting = '1;
          3: setting = '0;
          default: setting = CNT_W'($urandom_range(2, 20));
        endcase
        write_max_entries(setting);
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          roll = $urandom_range(99);
          if (roll < 50) op = OP_TOUCH;
          else if (roll < 70) op = OP_READ;
          else if (roll < 82) op = OP_DEL_KEY;
          else if (roll < 94) op = OP_DEL_INDEX;
          else if (roll < 97) op = OP_CLEAR;
          else op = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
          if ($urandom_range(99) < 85) begin
            key = key_pool[POOL_IDX_W'($urandom_range(POOL_SIZE - 1))];
          end else begin
            key = {$urandom, $urandom, $urandom, $urandom};
          end
          // aim half the indexes at live entries
          if (list_count != 0 && $urandom_range(1) == 1) begin
            pos = IDX_W'($urandom_range(list_count - 1));
          end else begin
            pos = IDX_W'($urandom_range(DEPTH - 1));
          end
          send_beat(op, key, pos);
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_list();
    test_small_list();
    test_truncation();
    test_random_traffic();
    settle_list();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mru_key_list_core: match");
    end else begin
      $display("mru_key_list_core: mismatch");
    end
    $finish;
  end

endmodule
